FILE: rtl/dqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqs_pkg
// shared types and constants of the double-ended queue with search
// ----------------------------------------------------------------------------
package dqs_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int REQ_W          = 3;
   localparam int VALUE_W        = 32;
   localparam int STATUS_W       = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_SEARCH     = 3'd4
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // shift controls broadcast to every cell of the row
   typedef struct packed {
      logic shift_up;    // take the lower neighbor (push front)
      logic shift_down;  // take the upper neighbor (pop front)
   } cell_ctrl_type;

endpackage

FILE: rtl/dqs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqs_req_if / dqs_rsp_if
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface dqs_req_if;
   logic                           valid;
   logic                           ready;
   logic [dqs_pkg::REQ_W-1:0]      req_type;
   logic [dqs_pkg::VALUE_W-1:0]    value;

   modport source (output valid, req_type, value, input ready);
   modport sink   (input valid, req_type, value, output ready);
endinterface

interface dqs_rsp_if #(
   parameter int POS_W = 4,
   parameter int CNT_W = 5
);
   logic                           valid;
   logic                           ready;
   logic [dqs_pkg::STATUS_W-1:0]   status;
   logic                           found;
   logic [POS_W-1:0]               position;
   logic [CNT_W-1:0]               occupancy;

   modport source (output valid, status, found, position, occupancy, input ready);
   modport sink   (input valid, status, found, position, occupancy, output ready);
endinterface

FILE: rtl/deque_with_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search_core
// bounded double-ended queue with search over a row of compare cells
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+--------------------------------------
//  req     | in  | valid / ready   | req_type, value
//  rsp     | out | valid / ready   | status, found, position, occupancy
//
//  one item accepted per cycle while rsp.ready keeps up; a response is held
//  in the match capture from the cell row, then priority encoded into the output register
//  the entry row shifts in place in the cycle an item is accepted, so every
//  item sees the row as the previous item left it
//  reset clears the entry count and both stage valid flags; entry data is
//  not cleared, cells at or above the count are never compared
//  with rsp.ready low the output register holds, the capture stage fills,
//  and then req.ready drops until the response is taken
// ----------------------------------------------------------------------------
module deque_with_search_core #(
   parameter int DEPTH      = dqs_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = dqs_pkg::DATA_WIDTH_DEF,
   parameter int POS_W      = $clog2(DEPTH),
   parameter int CNT_W      = $clog2(DEPTH + 1)
) (
   input  logic       clock,
   input  logic       reset,
   dqs_req_if.sink    req,
   dqs_rsp_if.source  rsp
);

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   // ---------------------------------------------------------------- decode
   logic                         accept;
   dqs_pkg::req_code_type        code;
   logic                         is_full;
   logic                         is_empty;
   logic [DATA_WIDTH-1:0]        key;

   assign accept   = req.valid && req.ready;
   assign code     = dqs_pkg::req_code_type'(req.req_type);

   // entry count, front entry always in cell 0
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign is_full  = (count_ff == DEPTH_C);
   assign is_empty = (count_ff == '0);

   // value cut or widened to the stored width
   generate
      if (DATA_WIDTH <= dqs_pkg::VALUE_W) begin : g_key_cut
         assign key = req.value[DATA_WIDTH-1:0];
      end else begin : g_key_ext
         assign key = {{(DATA_WIDTH - dqs_pkg::VALUE_W){1'b0}}, req.value};
      end
   endgenerate

   // per-item controls for the row and the count
   dqs_pkg::cell_ctrl_type  ctrl;
   logic                    push_back_go;
   logic [dqs_pkg::STATUS_W-1:0] status_now;
   logic                    search_now;

   always_comb begin
      ctrl         = '0;
      push_back_go = 1'b0;
      count_in     = count_ff;
      status_now   = dqs_pkg::ST_OK;
      search_now   = 1'b0;
      case (code)
         dqs_pkg::REQ_PUSH_FRONT: begin
            if (is_full) begin
               status_now = dqs_pkg::ST_FULL;
            end else begin
               ctrl.shift_up = accept;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         dqs_pkg::REQ_PUSH_BACK: begin
            if (is_full) begin
               status_now = dqs_pkg::ST_FULL;
            end else begin
               push_back_go = accept;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         dqs_pkg::REQ_POP_FRONT: begin
            if (is_empty) begin
               status_now = dqs_pkg::ST_EMPTY;
            end else begin
               ctrl.shift_down = accept;
               count_in        = count_ff - CNT_W'(1);
            end
         end
         dqs_pkg::REQ_POP_BACK: begin
            if (is_empty) begin
               status_now = dqs_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         dqs_pkg::REQ_SEARCH: begin
            search_now = 1'b1;
         end
         default: begin
            // undefined codes leave everything as is
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // ------------------------------------------------------------ cell row
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]      match_vec;

   generate
      for (genvar g = 0; g < DEPTH; g++) begin : g_cell
         logic [DATA_WIDTH-1:0] lower;
         logic [DATA_WIDTH-1:0] upper;

         // cell 0 takes the new value on push front
         if (g == 0) begin : g_lo_end
            assign lower = key;
         end else begin : g_lo_mid
            assign lower = cell_data[g-1];
         end

         // last cell keeps its data on pop front; it is out of use then
         if (g == DEPTH - 1) begin : g_hi_end
            assign upper = cell_data[g];
         end else begin : g_hi_mid
            assign upper = cell_data[g+1];
         end

         dqs_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock    (clock),
            .ctrl_i   (ctrl),
            .load_i   (push_back_go && (count_ff == CNT_W'(g))),
            .in_use_i (CNT_W'(g) < count_ff),
            .lower_i  (lower),
            .upper_i  (upper),
            .key_i    (key),
            .data_o   (cell_data[g]),
            .match_o  (match_vec[g])
         );
      end
   endgenerate

   // ------------------------------------------------------ capture stage
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [dqs_pkg::STATUS_W-1:0]  s1_status_ff;
   logic [DEPTH-1:0]              s1_match_ff;
   logic [CNT_W-1:0]              s1_count_ff;

   // output register
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [dqs_pkg::STATUS_W-1:0]  out_status_ff;
   logic                          out_found_ff;
   logic [POS_W-1:0]              out_pos_ff;
   logic [CNT_W-1:0]              out_occ_ff;

   logic                          out_load;
   logic                          enc_found;
   logic [POS_W-1:0]              enc_pos;

   assign out_load  = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || out_load;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status_now;
         s1_match_ff  <= search_now ? match_vec : '0;
         s1_count_ff  <= count_in;
      end
      if (out_load) begin
         out_status_ff <= s1_status_ff;
         out_found_ff  <= enc_found;
         out_pos_ff    <= enc_pos;
         out_occ_ff    <= s1_count_ff;
      end
   end

   dqs_first_match #(
      .DEPTH (DEPTH),
      .POS_W (POS_W)
   ) u_first_match (
      .match_i (s1_match_ff),
      .found_o (enc_found),
      .pos_o   (enc_pos)
   );

   assign rsp.valid     = out_valid_ff;
   assign rsp.status    = out_status_ff;
   assign rsp.found     = out_found_ff;
   assign rsp.position  = out_pos_ff;
   assign rsp.occupancy = out_occ_ff;

   // ----------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   a_pop_empty_keeps: assert property (@(posedge clock) disable iff (reset)
      accept && is_empty &&
      (code == dqs_pkg::REQ_POP_FRONT || code == dqs_pkg::REQ_POP_BACK)
      |=> count_ff == '0)
      else $error("pop from empty queue changed the count");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !is_full &&
      (code == dqs_pkg::REQ_PUSH_FRONT || code == dqs_pkg::REQ_PUSH_BACK)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push into free queue did not add one entry");

   a_miss_pos_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_found_ff |-> out_pos_ff == '0)
      else $error("position set without a match");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_load |=> s1_valid_ff)
      else $error("capture stage dropped an item while stalled");

endmodule

FILE: rtl/dqs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqs_cell
// one queue slot: holds an entry, shifts with its neighbors, compares a key
// ----------------------------------------------------------------------------
module dqs_cell #(
   parameter int DATA_WIDTH = dqs_pkg::DATA_WIDTH_DEF
) (
   input  logic                      clock,
   input  dqs_pkg::cell_ctrl_type    ctrl_i,
   input  logic                      load_i,
   input  logic                      in_use_i,
   input  logic [DATA_WIDTH-1:0]     lower_i,
   input  logic [DATA_WIDTH-1:0]     upper_i,
   input  logic [DATA_WIDTH-1:0]     key_i,
   output logic [DATA_WIDTH-1:0]     data_o,
   output logic                      match_o
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl_i.shift_up) begin
         data_in = lower_i;
      end else if (ctrl_i.shift_down) begin
         data_in = upper_i;
      end else if (load_i) begin
         data_in = key_i;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_o  = data_ff;
   assign match_o = in_use_i && (data_ff == key_i);

endmodule

FILE: rtl/dqs_first_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqs_first_match
// priority encoder: lowest set match bit gives the position from the front
// ----------------------------------------------------------------------------
module dqs_first_match #(
   parameter int DEPTH = dqs_pkg::DEPTH_DEF,
   parameter int POS_W = $clog2(DEPTH)
) (
   input  logic [DEPTH-1:0] match_i,
   output logic             found_o,
   output logic [POS_W-1:0] pos_o
);

   always_comb begin
      found_o = |match_i;
      pos_o   = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_i[i]) begin
            pos_o = POS_W'(i);
         end
      end
   end

endmodule

FILE: tb/deque_with_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search_checker
// watches the request and response channels, keeps its own copy of the
// deque, predicts each response and compares it field by field
// ----------------------------------------------------------------------------
module deque_with_search_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [dqs_pkg::REQ_W-1:0]    req_type,
   input  logic [dqs_pkg::VALUE_W-1:0]  req_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [dqs_pkg::STATUS_W-1:0] rsp_status,
   input  logic                         rsp_found,
   input  logic [3:0]                   rsp_position,
   input  logic [4:0]                   rsp_occupancy,
   output int                           fail_count,
   output int                           pending_count
);

   localparam int DEPTH = dqs_pkg::DEPTH_DEF;
   localparam int POS_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      dqs_pkg::status_type status;
      logic                found;
      logic [POS_W-1:0]    position;
      logic [CNT_W-1:0]    occupancy;
   } reply_type;

   // front of the deque is index 0
   logic [dqs_pkg::DATA_WIDTH_DEF-1:0] deque_entries[$];
   reply_type                          awaited_replies[$];
   reply_type                          next_reply;
   reply_type                          oldest_reply;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
      fail_count++;
   endtask

   task automatic apply_request(input logic [dqs_pkg::REQ_W-1:0] code,
                                input logic [dqs_pkg::VALUE_W-1:0] value,
                                output reply_type reply);
      logic [dqs_pkg::DATA_WIDTH_DEF-1:0] key;
      key   = value[dqs_pkg::DATA_WIDTH_DEF-1:0];
      reply = '{status: dqs_pkg::ST_OK, found: 1'b0, position: '0, occupancy: '0};
      case (code)
         dqs_pkg::REQ_PUSH_FRONT, dqs_pkg::REQ_PUSH_BACK: begin
            if (deque_entries.size() >= DEPTH)
               reply.status = dqs_pkg::ST_FULL;
            else if (code == dqs_pkg::REQ_PUSH_FRONT)
               deque_entries.push_front(key);
            else
               deque_entries.push_back(key);
         end
         dqs_pkg::REQ_POP_FRONT, dqs_pkg::REQ_POP_BACK: begin
            if (deque_entries.size() == 0)
               reply.status = dqs_pkg::ST_EMPTY;
            else if (code == dqs_pkg::REQ_POP_FRONT)
               void'(deque_entries.pop_front());
            else
               void'(deque_entries.pop_back());
         end
         dqs_pkg::REQ_SEARCH: begin
            // first match from the front wins
            for (int i = 0; i < deque_entries.size(); i++) begin
               if (deque_entries[i] == key) begin
                  reply.found    = 1'b1;
                  reply.position = POS_W'(i);
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      reply.occupancy = CNT_W'(deque_entries.size());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         deque_entries.delete();
         awaited_replies.delete();
      end else begin
         if (req_valid && req_ready) begin
            apply_request(req_type, req_value, next_reply);
            awaited_replies.push_back(next_reply);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("unexpected reply", 32'd0, 32'd1);
            end else begin
               oldest_reply = awaited_replies.pop_front();
               if (rsp_status !== oldest_reply.status)
                  report_mismatch("status", 32'(oldest_reply.status), 32'(rsp_status));
               if (rsp_found !== oldest_reply.found)
                  report_mismatch("found", 32'(oldest_reply.found), 32'(rsp_found));
               if (rsp_position !== oldest_reply.position)
                  report_mismatch("position", 32'(oldest_reply.position), 32'(rsp_position));
               if (rsp_occupancy !== oldest_reply.occupancy)
                  report_mismatch("occupancy", 32'(oldest_reply.occupancy),
                                  32'(rsp_occupancy));
            end
         end
      end
      pending_count <= awaited_replies.size();
   end

endmodule

FILE: tb/deque_with_search_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search_core_test
// drives push, pop, search and unused-code requests into the deque with random idling on
// both channels; a side checker predicts and compares every response
// ----------------------------------------------------------------------------
module deque_with_search_core_test;

   // request codes past search do nothing in the block
   localparam logic [dqs_pkg::REQ_W-1:0] FIRST_UNUSED_CODE = dqs_pkg::REQ_SEARCH + 3'd1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   // set during the stretch where neither side idles
   logic calm  = 1'b0;

   int fail_count;
   int pending_count;

   // a few values reused often, so searches hit and duplicates show up
   logic [dqs_pkg::VALUE_W-1:0] value_pool[8];

   dqs_req_if                           req_ch ();
   dqs_rsp_if #(.POS_W(4), .CNT_W(5))   rsp_ch ();

   deque_with_search_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   deque_with_search_checker checker_0 (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_type      (req_ch.req_type),
      .req_value     (req_ch.value),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_status    (rsp_ch.status),
      .rsp_found     (rsp_ch.found),
      .rsp_position  (rsp_ch.position),
      .rsp_occupancy (rsp_ch.occupancy),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response side stalls in about a fifth of the cycles
   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // present one item, with random idle cycles first, and hold it until taken
   task automatic send_request(input logic [dqs_pkg::REQ_W-1:0] code,
                               input logic [dqs_pkg::VALUE_W-1:0] value);
      while (!calm && $urandom_range(0, 99) < 20) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= code;
      req_ch.value    <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // push_pct steers the occupancy: high fills the deque, low drains it
   function automatic logic [dqs_pkg::REQ_W-1:0] pick_code(input int push_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3)
         return FIRST_UNUSED_CODE + dqs_pkg::REQ_W'($urandom_range(0, 2));
      if (roll < 23)
         return dqs_pkg::REQ_SEARCH;
      if ($urandom_range(0, 99) < push_pct)
         return ($urandom_range(0, 1) != 0) ? dqs_pkg::REQ_PUSH_FRONT
                                            : dqs_pkg::REQ_PUSH_BACK;
      return ($urandom_range(0, 1) != 0) ? dqs_pkg::REQ_POP_FRONT
                                         : dqs_pkg::REQ_POP_BACK;
   endfunction

   function automatic logic [dqs_pkg::VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 3) == 0)
         return $urandom;
      return value_pool[$urandom_range(0, 7)];
   endfunction

   initial begin
      int push_pct;

      req_ch.valid    = 1'b0;
      req_ch.req_type = dqs_pkg::REQ_PUSH_FRONT;
      req_ch.value    = '0;
      rsp_ch.ready    = 1'b0;

      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) value_pool[i] = $urandom;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // removal and search on an empty deque
      send_request(dqs_pkg::REQ_POP_FRONT, 32'hFFFF_FFFF);
      send_request(dqs_pkg::REQ_POP_BACK, 32'h0000_0000);
      send_request(dqs_pkg::REQ_SEARCH, 32'h0000_0000);

      // extremes of the value at both ends
      send_request(dqs_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
      send_request(dqs_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF);
      send_request(dqs_pkg::REQ_PUSH_FRONT, 32'hAAAA_AAAA);
      send_request(dqs_pkg::REQ_PUSH_BACK, 32'h5555_5555);
      send_request(dqs_pkg::REQ_SEARCH, 32'hFFFF_FFFF);
      send_request(dqs_pkg::REQ_SEARCH, 32'h0000_0000);
      send_request(dqs_pkg::REQ_SEARCH, 32'h1234_5678);

      // unused codes leave the deque alone
      for (int c = FIRST_UNUSED_CODE; c <= 7; c++)
         send_request(dqs_pkg::REQ_W'(c), 32'hFFFF_FFFF);

      // fill up, then push into a full deque from both ends
      for (int i = 0; i < 12; i++)
         send_request(dqs_pkg::REQ_PUSH_BACK, 32'hC0DE_0000 + i);
      send_request(dqs_pkg::REQ_PUSH_FRONT, 32'h8000_0001);
      send_request(dqs_pkg::REQ_PUSH_BACK, 32'h8000_0002);
      // match in the last slot
      send_request(dqs_pkg::REQ_SEARCH, 32'hC0DE_000B);
      send_request(dqs_pkg::REQ_POP_FRONT, 32'h0);
      send_request(dqs_pkg::REQ_POP_BACK, 32'h0);

      // random part: fill, drain and mixed phases, one phase with no idling
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 3)
            0: push_pct = 80;
            1: push_pct = 20;
            default: push_pct = 50;
         endcase
         calm <= (phase == 5);
         for (int n = 0; n < 100; n++)
            send_request(pick_code(push_pct), pick_value());
      end
      calm <= 1'b0;
      req_ch.valid <= 1'b0;

      // drain whatever is still in flight
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/dqs_pkg.sv
rtl/dqs_if.sv
rtl/dqs_cell.sv
rtl/dqs_first_match.sv
rtl/deque_with_search_core.sv
tb/deque_with_search_checker.sv
tb/deque_with_search_core_test.sv
